@@ rtl/core/vscf_pkg.sv @@
`timescale 1ns / 1ps
package vscf_pkg;

  typedef enum logic [1:0] {
    REQ_STEP = 2'd0,
    REQ_RX   = 2'd1,
    REQ_TX   = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  localparam logic [1:0] ST_NEXT = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_TX   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [3:0] M_INITREQ  = 4'd0;
  localparam logic [3:0] M_INITCONF = 4'd1;
  localparam logic [3:0] M_SELREQ   = 4'd2;
  localparam logic [3:0] M_SELCONF  = 4'd3;
  localparam logic [3:0] M_SELIND   = 4'd4;
  localparam logic [3:0] M_SELRSP   = 4'd5;
  localparam logic [3:0] M_QRYREQ   = 4'd6;
  localparam logic [3:0] M_QRYCONF  = 4'd7;
  localparam logic [3:0] M_EVTIND   = 4'd8;
  localparam logic [3:0] M_EVTRSP   = 4'd9;
  localparam logic [3:0] M_ACTRPT   = 4'd10;
  localparam logic [3:0] M_UNKNOWN  = 4'd11;

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_SLOW  = 3'd1;
  localparam logic [2:0] CFG_SHIGH = 3'd2;
  localparam logic [2:0] CFG_DWELL = 3'd3;
  localparam logic [2:0] CFG_BASE  = 3'd4;
  localparam logic [2:0] CFG_NUM   = 3'd5;

  localparam logic [47:0] TIMEOUT_EXTRA_US = 48'd1000;

  // classified command from front to back
  typedef struct packed {
    req_t        kind;
    logic        id_match;
    logic [47:0] now_us;
    logic [47:0] dwell_dl;    // now + dwell
    logic [3:0]  rx_msg;      // already clamped
    logic [31:0] rx_source;
    logic [31:0] rx_frequency;
    logic [7:0]  rx_modulation;
    logic [15:0] rx_program;
    logic        tx_ok;
  } cmd_t;

  // packed MSB first: fsm_state lands in the low bits
  typedef struct packed {
    logic        accepted;
    logic [31:0] transaction_id;
    logic [15:0] program_res;
    logic [7:0]  modulation;
    logic [31:0] frequency;
    logic [31:0] source_id;
    logic [3:0]  pending_msg;
    logic [1:0]  fsm_state;
  } res_t;

endpackage

@@ rtl/core/vscf_front.sv @@
`timescale 1ns / 1ps
module vscf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [47:0]        now_us,
  input  logic [39:0]        rx_session,
  input  logic [3:0]         rx_msg,
  input  logic [31:0]        rx_source,
  input  logic [31:0]        rx_frequency,
  input  logic [7:0]         rx_modulation,
  input  logic [15:0]        rx_program,
  input  logic               tx_ok,
  input  logic [15:0]        box_base,
  input  logic [15:0]        box_number,
  input  logic [31:0]        dwell_us,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output vscf_pkg::cmd_t     cmd
);
  import vscf_pkg::*;

  // two-entry queue
  cmd_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t       c;
  logic       push, pop;

  always_comb begin
    c.kind          = req_t'(req_type);
    c.id_match      = rx_session == {box_base, 8'd0, box_number};
    c.now_us        = now_us;
    c.dwell_dl      = now_us + {16'd0, dwell_us};
    c.rx_msg        = (rx_msg > M_UNKNOWN) ? M_UNKNOWN : rx_msg;
    c.rx_source     = rx_source;
    c.rx_frequency  = rx_frequency;
    c.rx_modulation = rx_modulation;
    c.rx_program    = rx_program;
    c.tx_ok         = tx_ok;
  end

  assign in_ready  = count != 2'd2;
  assign cmd_valid = count != 2'd0;
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ rtl/core/vscf_back.sv @@
`timescale 1ns / 1ps
module vscf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  vscf_pkg::cmd_t  cmd,
  input  logic [2:0]      mode_flags,
  input  logic [31:0]     source_low,
  input  logic [31:0]     source_high,
  output logic            out_valid,
  input  logic            out_ready,
  output vscf_pkg::res_t  res
);
  import vscf_pkg::*;

  logic [1:0]  mstate, mstate_next;
  logic [3:0]  mcode, mcode_next;
  logic [31:0] cur_src, cur_src_next, rot_src, rot_src_next;
  logic [31:0] tfreq, tfreq_next, txn, txn_next;
  logic [7:0]  tmod, tmod_next;
  logic [15:0] tprog, tprog_next;
  logic [47:0] to_dl, to_dl_next, dw_dl, dw_dl_next;
  logic        armed, armed_next, acc;
  logic [32:0] rot_inc;
  logic        sendable, dwelling, timed_out, fire;

  assign cmd_ready = !out_valid || out_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign rot_inc   = {1'b0, rot_src} + 33'd1;
  assign sendable  = mcode == M_INITREQ || mcode == M_SELREQ || mcode == M_SELRSP ||
                     mcode == M_QRYCONF || mcode == M_ACTRPT;
  assign dwelling  = cmd.now_us < dw_dl;
  assign timed_out = armed && cmd.now_us > to_dl;

  always_comb begin
    mstate_next  = mstate;  mcode_next = mcode;
    cur_src_next = cur_src; rot_src_next = rot_src;
    tfreq_next   = tfreq;   tmod_next = tmod;   tprog_next = tprog;
    txn_next     = txn;     to_dl_next = to_dl; dw_dl_next = dw_dl;
    armed_next   = armed;   acc = 1'b0;
    unique case (cmd.kind)
      REQ_STEP: begin
        if (mstate != ST_DONE) begin
          case (mcode)
            M_SELIND: begin mcode_next = M_SELRSP; mstate_next = ST_TX; end
            M_SELRSP: begin
              mcode_next  = M_SELREQ;
              mstate_next = mode_flags[2] ? ST_TX : ST_NEXT;
            end
            M_QRYREQ: begin mcode_next = M_QRYCONF; mstate_next = ST_TX; end
            M_EVTIND: begin mcode_next = M_EVTRSP; mstate_next = ST_TX; end
            M_QRYCONF, M_EVTRSP, M_ACTRPT: begin
              mcode_next = M_SELREQ; mstate_next = ST_NEXT;
            end
            M_INITCONF: begin
              mcode_next = M_SELREQ; mstate_next = ST_NEXT; cur_src_next = '0;
            end
            M_SELCONF: begin
              if (mode_flags[0]) begin
                mcode_next = M_SELREQ; mstate_next = ST_NEXT;
              end else begin
                mstate_next = ST_DONE;
              end
            end
            default: begin
              if (mstate == ST_WAIT) begin
                if (cur_src == '0) mstate_next = ST_DONE;
                else if (timed_out) mstate_next = ST_NEXT;
              end else if (mstate == ST_NEXT) begin
                if (mcode == M_INITREQ) begin
                  if (mode_flags[1]) mcode_next = M_SELREQ;
                  else mstate_next = ST_TX;
                end else if (mcode == M_SELREQ && !dwelling) begin
                  cur_src_next = rot_src;
                  mstate_next  = ST_TX;
                  rot_src_next = (rot_inc > {1'b0, source_high}) ? source_low
                                                                 : rot_inc[31:0];
                end
              end
            end
          endcase
        end
      end
      REQ_RX: begin
        if (cmd.id_match) begin
          acc         = 1'b1;
          armed_next  = 1'b0;
          mcode_next  = cmd.rx_msg;
          mstate_next = ST_NEXT;
          if (cmd.rx_msg == M_SELCONF || cmd.rx_msg == M_SELIND) begin
            cur_src_next = cmd.rx_source;
            tfreq_next   = cmd.rx_frequency;
            tmod_next    = cmd.rx_modulation;
            tprog_next   = cmd.rx_program;
          end
        end
      end
      REQ_TX: begin
        if (sendable) begin
          acc      = 1'b1;
          txn_next = txn + 32'd1;
          if (cmd.tx_ok) begin
            mstate_next = ST_WAIT;
            to_dl_next  = cmd.dwell_dl + TIMEOUT_EXTRA_US;
            armed_next  = 1'b1;
            if (mcode == M_SELREQ) dw_dl_next = cmd.dwell_dl;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= ST_NEXT; mcode <= M_INITREQ;
      cur_src <= 32'd1; rot_src <= 32'd1;
      tfreq <= '0; tmod <= '0; tprog <= '0; txn <= 32'd1;
      to_dl <= '0; dw_dl <= '0; armed <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        mstate <= mstate_next; mcode <= mcode_next;
        cur_src <= cur_src_next; rot_src <= rot_src_next;
        tfreq <= tfreq_next; tmod <= tmod_next; tprog <= tprog_next;
        txn <= txn_next; to_dl <= to_dl_next; dw_dl <= dw_dl_next;
        armed <= armed_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (fire) begin
      res.fsm_state      <= mstate_next;
      res.pending_msg    <= mcode_next;
      res.source_id      <= cur_src_next;
      res.frequency      <= tfreq_next;
      res.modulation     <= tmod_next;
      res.program_res    <= tprog_next;
      res.transaction_id <= txn_next;
      res.accepted       <= acc;
    end
  end
endmodule

@@ rtl/core/video_session_client_fsm_core.sv @@
`timescale 1ns / 1ps
// Session client FSM: front classifies items into a 2-deep queue, back applies them.
// Each accepted item is first written into the front queue; the back unit then registers its result.
// Throughput: one item per cycle sustained while m_tready holds; the back unit does one update per cycle.
// Reset (rst, synchronous, active high) clears config to defaults, FSM state,
// queue and output register.
module video_session_client_fsm_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type[1:0] now_us[49:2] rx_session[89:50] rx_msg[93:90] rx_source[125:94]
  // rx_frequency[157:126] rx_modulation[165:158] rx_program[181:166] tx_ok[182]
  input  logic [183:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // fsm_state[1:0] pending_msg[5:2] source_id[37:6] frequency[69:38]
  // modulation[77:70] program_res[93:78] transaction_id[125:94] accepted[126]
  output logic [127:0] m_tdata
);
  import vscf_pkg::*;

  logic [2:0]  mode_flags;
  logic [31:0] source_low, source_high, dwell_us;
  logic [15:0] box_base, box_number;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags <= '0; source_low <= 32'd1; source_high <= 32'd1;
      dwell_us <= '0; box_base <= '0; box_number <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_flags  <= cfg_data[2:0];
        CFG_SLOW:  source_low  <= cfg_data;
        CFG_SHIGH: source_high <= cfg_data;
        CFG_DWELL: dwell_us    <= cfg_data;
        CFG_BASE:  box_base    <= cfg_data[15:0];
        CFG_NUM:   box_number  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  vscf_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .req_type(s_tdata[1:0]), .now_us(s_tdata[49:2]), .rx_session(s_tdata[89:50]),
    .rx_msg(s_tdata[93:90]), .rx_source(s_tdata[125:94]),
    .rx_frequency(s_tdata[157:126]), .rx_modulation(s_tdata[165:158]),
    .rx_program(s_tdata[181:166]), .tx_ok(s_tdata[182]),
    .box_base, .box_number, .dwell_us,
    .cmd_valid, .cmd_ready, .cmd
  );

  vscf_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .mode_flags, .source_low, .source_high,
    .out_valid(m_tvalid), .out_ready(m_tready), .res
  );

  assign m_tdata = {1'b0, res};
endmodule

@@ rtl/core/vscf_checker.sv @@
`timescale 1ns / 1ps
module vscf_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("valid after reset");
  a_pad: assert property (@(posedge clk) m_tvalid |-> !m_tdata[127])
    else $error("pad bit set");
  a_code: assert property (@(posedge clk) m_tvalid |-> m_tdata[5:2] <= 4'd11)
    else $error("bad pending code");
  a_acc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[126] |-> m_tdata[5:2] != 4'd11 || m_tdata[1:0] == 2'd0)
    else $error("accepted unknown not in next");
endmodule

bind video_session_client_fsm_core vscf_checker u_chk (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import vscf_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // req_type, now_us, rx_session, rx_msg, rx_source, rx_frequency,
  // rx_modulation, rx_program, tx_ok (low bit up)
  logic [183:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // fsm_state, pending_msg, source_id, frequency, modulation, program_res,
  // transaction_id, accepted (low bit up)
  logic [127:0] m_tdata;

  video_session_client_fsm_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One input item, fields as on the port.
  typedef struct packed {
    logic        tx_ok;
    logic [15:0] prog;
    logic [7:0]  modulation;
    logic [31:0] frequency;
    logic [31:0] source;
    logic [3:0]  msg;
    logic [39:0] session;
    logic [47:0] now;
    logic [1:0]  kind;
  } item_t;

  // Shadow configuration
  logic [2:0]  sh_mode;
  logic [31:0] sh_slow, sh_shigh, sh_dwell;
  logic [15:0] sh_base, sh_num;
  // Shadow session state
  logic [1:0]  sh_state;
  logic [3:0]  sh_code;
  logic [31:0] sh_cur, sh_rot, sh_freq, sh_txn;
  logic [7:0]  sh_mod;
  logic [15:0] sh_prog;
  logic [47:0] sh_to_dl, sh_dw_dl;
  logic        sh_armed;

  res_t        expected_results[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          n_items = 0;
  int          n_results = 0;
  int          idle_cycles = 0;
  logic [47:0] clock_us = 48'd100;

  function automatic logic sendable(logic [3:0] m);
    return m == M_INITREQ || m == M_SELREQ || m == M_SELRSP ||
           m == M_QRYCONF || m == M_ACTRPT;
  endfunction

  // Transition rules for a step item.
  function automatic void step_session(logic [47:0] now);
    logic        dwelling;
    logic        timed_out;
    logic [32:0] nxt;
    dwelling  = sh_state == ST_NEXT && now < sh_dw_dl;
    timed_out = sh_state == ST_WAIT && sh_armed && now > sh_to_dl;
    if (sh_state == ST_DONE) return;
    case (sh_code)
      M_SELIND: begin sh_code = M_SELRSP; sh_state = ST_TX; return; end
      M_SELRSP: begin
        sh_code = M_SELREQ;
        sh_state = sh_mode[2] ? ST_TX : ST_NEXT;
        return;
      end
      M_QRYREQ: begin sh_code = M_QRYCONF; sh_state = ST_TX; return; end
      M_QRYCONF, M_EVTRSP, M_ACTRPT: begin
        sh_code = M_SELREQ; sh_state = ST_NEXT; return;
      end
      M_EVTIND: begin sh_code = M_EVTRSP; sh_state = ST_TX; return; end
      M_INITCONF: begin
        sh_code = M_SELREQ; sh_state = ST_NEXT; sh_cur = '0; return;
      end
      M_SELCONF: begin
        if (sh_mode[0]) begin
          sh_code = M_SELREQ; sh_state = ST_NEXT;
        end else begin
          sh_state = ST_DONE;
        end
        return;
      end
      default: ;
    endcase
    if (sh_state == ST_WAIT) begin
      if (sh_cur == '0) sh_state = ST_DONE;
      else if (timed_out) sh_state = ST_NEXT;
    end else if (sh_state == ST_NEXT) begin
      if (sh_code == M_INITREQ) begin
        if (sh_mode[1]) sh_code = M_SELREQ;
        else sh_state = ST_TX;
      end else if (sh_code == M_SELREQ && !dwelling) begin
        nxt = {1'b0, sh_rot} + 33'd1;
        sh_cur = sh_rot;
        sh_state = ST_TX;
        sh_rot = (nxt > {1'b0, sh_shigh}) ? sh_slow : nxt[31:0];
      end
    end
  endfunction

  function automatic res_t predict_session(item_t it);
    res_t r;
    logic acc;
    logic [3:0] code;
    acc = 1'b0;
    case (it.kind)
      REQ_STEP: step_session(it.now);
      REQ_RX: begin
        if (it.session == {sh_base, 8'h00, sh_num}) begin
          acc = 1'b1;
          code = (it.msg > M_UNKNOWN) ? M_UNKNOWN : it.msg;
          sh_armed = 1'b0;
          sh_code = code;
          sh_state = ST_NEXT;
          if (code == M_SELCONF || code == M_SELIND) begin
            sh_cur = it.source; sh_freq = it.frequency;
            sh_mod = it.modulation; sh_prog = it.prog;
          end
        end
      end
      REQ_TX: begin
        if (sendable(sh_code)) begin
          acc = 1'b1;
          sh_txn = sh_txn + 32'd1;
          if (it.tx_ok) begin
            sh_state = ST_WAIT;
            sh_to_dl = it.now + {16'd0, sh_dwell} + TIMEOUT_EXTRA_US;
            sh_armed = 1'b1;
            if (sh_code == M_SELREQ) sh_dw_dl = it.now + {16'd0, sh_dwell};
          end
        end
      end
      default: ;
    endcase
    r.fsm_state = sh_state; r.pending_msg = sh_code; r.source_id = sh_cur;
    r.frequency = sh_freq; r.modulation = sh_mod; r.program_res = sh_prog;
    r.transaction_id = sh_txn; r.accepted = acc;
    return r;
  endfunction

  function automatic void reset_shadow();
    sh_mode = '0; sh_slow = 32'd1; sh_shigh = 32'd1; sh_dwell = '0;
    sh_base = '0; sh_num = '0;
    sh_state = ST_NEXT; sh_code = M_INITREQ; sh_cur = 32'd1; sh_rot = 32'd1;
    sh_freq = '0; sh_mod = '0; sh_prog = '0; sh_txn = 32'd1;
    sh_to_dl = '0; sh_armed = 1'b0; sh_dw_dl = '0;
  endfunction

  // Only called while idle; drives at the falling edge.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_MODE:  sh_mode = val[2:0];
      CFG_SLOW:  sh_slow = val;
      CFG_SHIGH: sh_shigh = val;
      CFG_DWELL: sh_dwell = val;
      CFG_BASE:  sh_base = val[15:0];
      CFG_NUM:   sh_num = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Send one item; predict at acceptance. Valid stays up for a following item.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {1'b0, it};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_session(it));
    n_items++;
    @(negedge clk);
  endtask

  function automatic logic [39:0] my_session();
    return {sh_base, 8'h00, sh_num};
  endfunction

  function automatic item_t rand_item(int kind);
    item_t it;
    it.kind = kind[1:0];
    it.now = clock_us;
    it.session = $urandom_range(9) == 0 ? 40'({$urandom, $urandom}) : my_session();
    it.msg = 4'($urandom_range(15));
    it.source = $urandom_range(3) == 0 ? $urandom : $urandom_range(5);
    it.frequency = $urandom;
    it.modulation = 8'($urandom);
    it.prog = 16'($urandom);
    it.tx_ok = $urandom_range(4) != 0;
    return it;
  endfunction

  // Output checking and receiver stalls
  always @(posedge clk) begin
    res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[126:0]);
      if (expected_results.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        n_results++;
        if (got.fsm_state != want.fsm_state) begin
          $error("fsm_state exp %0d got %0d", want.fsm_state, got.fsm_state); errors++;
        end
        if (got.pending_msg != want.pending_msg) begin
          $error("pending_msg exp %0d got %0d", want.pending_msg, got.pending_msg); errors++;
        end
        if (got.source_id != want.source_id) begin
          $error("source_id exp %0h got %0h", want.source_id, got.source_id); errors++;
        end
        if (got.frequency != want.frequency) begin
          $error("frequency exp %0h got %0h", want.frequency, got.frequency); errors++;
        end
        if (got.modulation != want.modulation) begin
          $error("modulation exp %0h got %0h", want.modulation, got.modulation); errors++;
        end
        if (got.program_res != want.program_res) begin
          $error("program_res exp %0h got %0h", want.program_res, got.program_res); errors++;
        end
        if (got.transaction_id != want.transaction_id) begin
          $error("transaction_id exp %0h got %0h", want.transaction_id,
                 got.transaction_id); errors++;
        end
        if (got.accepted != want.accepted) begin
          $error("accepted exp %0d got %0d", want.accepted, got.accepted); errors++;
        end
      end
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Directed: init, select, tune, every code, identity mismatch, bad kind.
  task automatic test_directed();
    item_t it;
    write_reg(CFG_BASE, 32'hFFFF);
    write_reg(CFG_NUM, 32'h0000);
    write_reg(CFG_DWELL, 32'd0);
    it = rand_item(REQ_STEP); send_item(it);            // initreq -> tx
    it = rand_item(REQ_TX); it.tx_ok = 1; send_item(it); // wait
    clock_us = clock_us + 5000;
    it = rand_item(REQ_STEP); it.now = clock_us; send_item(it); // timeout
    it = rand_item(REQ_RX); it.session = my_session(); it.msg = M_INITCONF; send_item(it);
    it = rand_item(REQ_STEP); send_item(it);
    for (int c = 0; c < 16; c++) begin
      it = rand_item(REQ_RX);
      it.session = my_session() ^ ((c == 5) ? 40'h0000_0100_00 : 40'h0);
      it.msg = c[3:0]; it.source = '1; it.frequency = '1; it.modulation = '1;
      it.prog = '1;
      send_item(it);
      it = rand_item(c % 3); it.tx_ok = c[0]; it.now = '1; send_item(it);
    end
    it = rand_item(REQ_NONE); it = '1; send_item(it);
    it = '0; it.kind = REQ_TX; send_item(it);
    drain();
  endtask

  // Mostly well-formed exchanges with random content and some noise.
  task automatic test_random(int count);
    item_t it;
    int k;
    for (int i = 0; i < count; i++) begin
      clock_us = clock_us + $urandom_range(3000);
      k = $urandom_range(99);
      if (k < 40) it = rand_item(REQ_STEP);
      else if (k < 70) it = rand_item(REQ_TX);
      else if (k < 97) it = rand_item(REQ_RX);
      else it = rand_item(REQ_NONE);
      if ($urandom_range(49) == 0) it.now = 48'({$urandom, $urandom});
      if ($urandom_range(29) == 0) it.session = 40'({$urandom, $urandom});
      if (it.kind == REQ_RX && $urandom_range(3) != 0) it.msg = 4'($urandom_range(11));
      send_item(it);
      if (i == count / 2) drain();   // sender holds off until all results are in
    end
    drain();
  endtask

  // Configuration sweep with extremes
  task automatic test_settings(int phase);
    write_reg(CFG_MODE, phase[2:0]);
    case (phase % 4)
      0: begin write_reg(CFG_SLOW, 1); write_reg(CFG_SHIGH, 4); end
      1: begin write_reg(CFG_SLOW, 32'hFFFF_FFFE); write_reg(CFG_SHIGH, '1); end
      2: begin write_reg(CFG_SLOW, 0); write_reg(CFG_SHIGH, 0); end
      default: begin write_reg(CFG_SLOW, $urandom); write_reg(CFG_SHIGH, $urandom); end
    endcase
    write_reg(CFG_DWELL, (phase == 5) ? 32'hFFFF_FFFF : $urandom_range(4000));
    write_reg(CFG_BASE, (phase == 6) ? 32'h0 : $urandom);
    write_reg(CFG_NUM, (phase == 7) ? 32'hFFFF : $urandom);
    test_random(100);
  endtask

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 8; recv_idle_pct = 50;
    test_directed();
    for (int p = 0; p < 3; p++) test_settings(p);
    send_idle_pct = 50; recv_idle_pct = 8;
    for (int p = 3; p < 6; p++) test_settings(p);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int p = 6; p < 8; p++) test_settings(p);
    repeat (20) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Ran %0d items (%0d results) over 8 mode/rotation/dwell/identity settings,",
             n_items, n_results);
    $display("with stalls on either side and a full-throughput phase.");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
